@@ hw/rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes, defaults and controller-to-datapath types for the
// positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CapacityDefault     = 16;
	localparam int ElementWidthDefault = 32;

	localparam int KindWidth   = 2;
	localparam int PosWidth    = 5;
	localparam int ValueWidth  = 32;
	localparam int StatusWidth = 2;
	localparam int CountOutWidth = 5;

	localparam int InDataWidth  = 40;
	localparam int OutDataWidth = 40;

	localparam logic [KindWidth-1:0] KIND_INSERT = 2'd0;
	localparam logic [KindWidth-1:0] KIND_DELETE = 2'd1;
	localparam logic [KindWidth-1:0] KIND_FIND   = 2'd2;

	localparam logic [StatusWidth-1:0] STATUS_OK   = 2'd0;
	localparam logic [StatusWidth-1:0] STATUS_BAD  = 2'd1;
	localparam logic [StatusWidth-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

@@ hw/rtl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: takes one request, runs it through the datapath,
// then holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ple_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load  = in_ready && in_valid;
	assign cmd.exec  = (state_q == ST_EXEC);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec ##1 out_valid)
		else $error("accepted request did not execute and present a result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before transfer");

endmodule

@@ hw/rtl/ple_datapath.sv @@
// ----------------------------------------------------------------------------
// ple_datapath
// Request registers, a row of entry cells that all shift at once, the
// entry count and the result registers.
// ----------------------------------------------------------------------------
module ple_datapath #(
	parameter int CAPACITY      = ple_pkg::CapacityDefault,
	parameter int ELEMENT_WIDTH = ple_pkg::ElementWidthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ple_pkg::cmd_t                        cmd,
	input  logic [ple_pkg::KindWidth-1:0]        kind,
	input  logic signed [ple_pkg::PosWidth-1:0]  position,
	input  logic signed [ple_pkg::ValueWidth-1:0] value,
	output logic [ple_pkg::StatusWidth-1:0]      status,
	output logic signed [ple_pkg::ValueWidth-1:0] found_value,
	output logic [ple_pkg::CountOutWidth-1:0]    entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > ple_pkg::PosWidth) ? CW : ple_pkg::PosWidth) + 1;

	logic [ple_pkg::KindWidth-1:0]         kind_q;
	logic signed [ple_pkg::PosWidth-1:0]   pos_q;
	logic [ple_pkg::ValueWidth-1:0]        value_q;

	logic [ELEMENT_WIDTH-1:0]              entries_q [CAPACITY];
	logic [CW-1:0]                         count_q;

	logic [ple_pkg::StatusWidth-1:0]       status_q;
	logic [ple_pkg::ValueWidth-1:0]        found_q;

	logic signed [PW-1:0] pos_ext;
	logic signed [PW-1:0] slot;
	logic signed [PW-1:0] last_ext;
	logic                 pos_in_list;
	logic                 pos_ins_ok;
	logic                 full;
	logic                 do_insert;
	logic                 do_delete;
	logic                 do_find;
	logic [ELEMENT_WIDTH-1:0] store_word;
	logic [ELEMENT_WIDTH-1:0] read_word;

	assign pos_ext     = PW'(pos_q);
	assign slot        = pos_ext + PW'(1);
	assign last_ext    = $signed({1'b0, count_q}) - PW'(1);
	assign pos_in_list = (pos_ext >= PW'(0)) && (pos_ext <= last_ext);
	assign pos_ins_ok  = (pos_ext >= -PW'(1)) && (pos_ext <= last_ext);
	assign full        = (count_q == CW'(CAPACITY));

	assign do_insert = (kind_q == ple_pkg::KIND_INSERT) && pos_ins_ok && !full;
	assign do_delete = (kind_q == ple_pkg::KIND_DELETE) && pos_in_list;
	assign do_find   = (kind_q == ple_pkg::KIND_FIND) && pos_in_list;

	assign store_word = ELEMENT_WIDTH'({{32{value_q[31]}}, value_q});
	assign read_word  = entries_q[pos_ext[IW-1:0]];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			pos_q   <= position;
			value_q <= value;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic signed [PW-1:0] IDX = PW'(i);
		always_ff @(posedge clk) begin
			if (cmd.exec && do_insert) begin
				if (IDX == slot) begin
					entries_q[i] <= store_word;
				end else if (IDX > slot) begin
					entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.exec && do_delete) begin
				if ((IDX >= pos_ext) && (i + 1 < CAPACITY)) begin
					entries_q[i] <= entries_q[(i + 1 < CAPACITY) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (do_delete) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_insert || do_delete || do_find) begin
				status_q <= ple_pkg::STATUS_OK;
			end else if ((kind_q == ple_pkg::KIND_INSERT) && pos_ins_ok) begin
				status_q <= ple_pkg::STATUS_FULL;
			end else begin
				status_q <= ple_pkg::STATUS_BAD;
			end
			if (do_find) begin
				found_q <= 32'({{64{read_word[ELEMENT_WIDTH-1]}}, read_word});
			end else begin
				found_q <= '0;
			end
		end
	end

	assign status      = status_q;
	assign found_value = found_q;
	assign entry_count = ple_pkg::CountOutWidth'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_insert) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count changed outside execution");

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words addressed by position: insert after an
// entry, delete an entry, or read an entry, one result per request.
// ----------------------------------------------------------------------------
// The request is registered at its input transfer. In the next cycle every
// entry cell shifts at once while the result registers load. The result is
// then offered from the result registers in the state after execution, and
// it can be transferred as soon as it is offered. The next request is taken
// in the cycle after the result has been transferred, so the engine takes no
// new request while one is executing or its result waits, and a sink stall
// holds the next request off. Positions run from -1 to 15 on the 5-bit field;
// entry contents are undefined until written, and a find never returns one outside the current count.
module positional_list_engine #(
	parameter int CAPACITY      = ple_pkg::CapacityDefault,
	parameter int ELEMENT_WIDTH = ple_pkg::ElementWidthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// kind [1:0], position [6:2], value [38:7], zero [39]
	input  logic [ple_pkg::InDataWidth-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status [1:0], found_value [33:2], entry_count [38:34], zero [39]
	output logic [ple_pkg::OutDataWidth-1:0] m_tdata
);

	ple_pkg::cmd_t cmd;

	logic [ple_pkg::StatusWidth-1:0]        status;
	logic signed [ple_pkg::ValueWidth-1:0]  found_value;
	logic [ple_pkg::CountOutWidth-1:0]      entry_count;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ple_datapath #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (s_tdata[1:0]),
		.position    ($signed(s_tdata[6:2])),
		.value       ($signed(s_tdata[38:7])),
		.status      (status),
		.found_value (found_value),
		.entry_count (entry_count)
	);

	assign m_tdata = {1'b0, entry_count, found_value, status};

endmodule
